/* src/mttg_pkg.sv */
// ----------------------------------------------------------------------------
// mttg_pkg: shared constants and functions for the multimode test tone generator
// Holds the mode and register codes, the fixed tone set and the function
// that builds the quarter-wave sine table at elaboration.
// ----------------------------------------------------------------------------
package mttg_pkg;

    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_TABLE_ADDR_BITS = 10;
    localparam int RATE_HZ             = 44100;

    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 15;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [PEAK_W-1:0] FULL_Q15  = 15'd32767;
    localparam logic [PEAK_W-1:0] PEAK_RST  = 15'd26213;

    // mode codes
    localparam logic [2:0] MODE_SINE    = 3'd0;
    localparam logic [2:0] MODE_CHIRP   = 3'd1;
    localparam logic [2:0] MODE_SQUARE  = 3'd2;
    localparam logic [2:0] MODE_SILENCE = 3'd3;
    localparam logic [2:0] MODE_IMPULSE = 3'd4;
    localparam logic [2:0] MODE_TONES   = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 3'd4;

    localparam int NUM_TONES = 4;
    localparam logic [63:0] TONE_FREQ [NUM_TONES] = '{64'd100, 64'd1000, 64'd5000, 64'd10000};

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TAYLOR_DIV [6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};

    // sin(m / 2^qb * pi/2) in Q15, Taylor series in Q30 to the x^13 term
    function automatic logic [PEAK_W-1:0] quarter_sine(input int m, input int qb);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint r;
        x = (longint'(m) * HALF_PI_Q30 + (longint'(1) <<< (qb - 1))) >>> qb;
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >>> 30) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum * 64'sd32767 + (longint'(1) <<< 29)) >>> 30;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        return r[PEAK_W-1:0];
    endfunction

endpackage

/* src/multimode_test_tone_generator_core.sv */
// ----------------------------------------------------------------------------
// multimode_test_tone_generator_core: DDS test tone source
// Pipeline: an accepted tick item enters the input register, then passes one stage
// each for table lookup, amplitude multiply and divide by full scale, which gives
// the result. Throughput: one item per cycle unless m_tready stalls; phase state advances at accept.
// Reset (aresetn low, synchronous) loads register defaults, clears phases,
// step and sample count, and empties the pipeline.
// ----------------------------------------------------------------------------
module multimode_test_tone_generator_core #(
    parameter int PHASE_BITS      = mttg_pkg::DEF_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = mttg_pkg::DEF_TABLE_ADDR_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [mttg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mttg_pkg::CFG_W-1:0]        cfg_wdata,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [0] restart, [7:1] zero

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mttg_pkg::SAMPLE_W-1:0]     m_tdata,   // [15:0] sample (signed)
    output logic                              m_tlast
);

    localparam int NT = mttg_pkg::NUM_TONES;
    localparam int AW = TABLE_ADDR_BITS;

    localparam logic [PHASE_BITS-1:0] TONE_STEP [NT] = '{
        PHASE_BITS'(((mttg_pkg::TONE_FREQ[0] << PHASE_BITS) + 64'(mttg_pkg::RATE_HZ / 2))
                    / 64'(mttg_pkg::RATE_HZ)),
        PHASE_BITS'(((mttg_pkg::TONE_FREQ[1] << PHASE_BITS) + 64'(mttg_pkg::RATE_HZ / 2))
                    / 64'(mttg_pkg::RATE_HZ)),
        PHASE_BITS'(((mttg_pkg::TONE_FREQ[2] << PHASE_BITS) + 64'(mttg_pkg::RATE_HZ / 2))
                    / 64'(mttg_pkg::RATE_HZ)),
        PHASE_BITS'(((mttg_pkg::TONE_FREQ[3] << PHASE_BITS) + 64'(mttg_pkg::RATE_HZ / 2))
                    / 64'(mttg_pkg::RATE_HZ))
    };

    // configuration
    logic [2:0]                     mode_reg;
    logic [31:0]                    phase_step_reg;
    logic [31:0]                    sweep_delta_reg;
    logic [mttg_pkg::PEAK_W-1:0]    peak_reg;
    logic [31:0]                    total_reg;

    // generator state
    logic [PHASE_BITS-1:0]          phase_acc_reg, phase_acc_next;
    logic [31:0]                    cur_step_reg, cur_step_next;
    logic [31:0]                    idx_reg, idx_next;
    logic [PHASE_BITS-1:0]          tone_reg [NT];
    logic [PHASE_BITS-1:0]          tone_next [NT];

    // accept path
    logic                           in_fire;
    logic                           restart;
    logic                           produce;
    logic [PHASE_BITS-1:0]          eff_phase;
    logic [31:0]                    eff_step;
    logic [31:0]                    eff_idx;
    logic [PHASE_BITS-1:0]          eff_tone [NT];
    logic [PHASE_BITS-1:0]          step_ext;
    logic [AW-1:0]                  addr_next [NT];

    // pipeline
    logic                           rdy1, rdy2, rdy3, rdy_out;
    logic                           s1_valid_reg;
    logic [2:0]                     s1_mode_reg;
    logic [AW-1:0]                  s1_addr_reg [NT];
    logic                           s1_sq_neg_reg;
    logic                           s1_first_reg;
    logic                           s1_last_reg;

    logic signed [mttg_pkg::SAMPLE_W-1:0] wave [NT];
    logic signed [17:0]             val;
    logic                           s2_valid_reg;
    logic [16:0]                    s2_mag_reg;
    logic                           s2_neg_reg;
    logic                           s2_div4_reg;
    logic                           s2_last_reg;

    logic [31:0]                    prod;
    logic                           s3_valid_reg;
    logic [29:0]                    s3_x_reg;
    logic                           s3_neg_reg;
    logic                           s3_last_reg;

    logic [30:0]                    est_sum;
    logic [15:0]                    q0;
    logic [31:0]                    rem;
    logic [15:0]                    quot;
    logic                           m_valid_reg;
    logic [mttg_pkg::SAMPLE_W-1:0]  m_sample_reg;
    logic                           m_last_reg;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign rdy_out  = !m_valid_reg || m_tready;
    assign rdy3     = !s3_valid_reg || rdy_out;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_tready = rdy1;
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sample_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= mttg_pkg::MODE_SINE;
            phase_step_reg  <= '0;
            sweep_delta_reg <= '0;
            peak_reg        <= mttg_pkg::PEAK_RST;
            total_reg       <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                mttg_pkg::REG_MODE:  mode_reg        <= cfg_wdata[2:0];
                mttg_pkg::REG_STEP:  phase_step_reg  <= cfg_wdata;
                mttg_pkg::REG_SWEEP: sweep_delta_reg <= cfg_wdata;
                mttg_pkg::REG_PEAK:  peak_reg        <= cfg_wdata[mttg_pkg::PEAK_W-1:0];
                mttg_pkg::REG_TOTAL: total_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State update at accept
    // ------------------------------------------------------------------
    always_comb begin
        restart   = s_tdata[0];
        step_ext  = PHASE_BITS'(phase_step_reg);
        eff_phase = restart ? '0 : phase_acc_reg;
        eff_step  = restart ? phase_step_reg : cur_step_reg;
        eff_idx   = restart ? '0 : idx_reg;
        for (int j = 0; j < NT; j++) begin
            eff_tone[j] = restart ? '0 : tone_reg[j];
        end
        produce = (eff_idx < total_reg);

        phase_acc_next = eff_phase;
        cur_step_next  = eff_step;
        idx_next       = produce ? eff_idx + 32'd1 : eff_idx;
        for (int j = 0; j < NT; j++) begin
            tone_next[j] = eff_tone[j];
        end
        if (produce) begin
            case (mode_reg) inside
                mttg_pkg::MODE_SINE, mttg_pkg::MODE_SQUARE: begin
                    phase_acc_next = eff_phase + step_ext;
                end
                mttg_pkg::MODE_CHIRP: begin
                    phase_acc_next = eff_phase + PHASE_BITS'(eff_step);
                    cur_step_next  = eff_step + sweep_delta_reg;
                end
                mttg_pkg::MODE_TONES: begin
                    for (int j = 0; j < NT; j++) begin
                        tone_next[j] = eff_tone[j] + TONE_STEP[j];
                    end
                end
                default: ;
            endcase
        end

        for (int j = 0; j < NT; j++) begin
            addr_next[j] = eff_tone[j][PHASE_BITS-1 -: AW];
        end
        if (mode_reg != mttg_pkg::MODE_TONES) begin
            addr_next[0] = eff_phase[PHASE_BITS-1 -: AW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
            cur_step_reg  <= '0;
            idx_reg       <= '0;
            for (int j = 0; j < NT; j++) begin
                tone_reg[j] <= '0;
            end
        end else if (in_fire) begin
            phase_acc_reg <= phase_acc_next;
            cur_step_reg  <= cur_step_next;
            idx_reg       <= idx_next;
            for (int j = 0; j < NT; j++) begin
                tone_reg[j] <= tone_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register (an item with no result becomes a bubble)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (rdy1) begin
            s1_valid_reg <= in_fire && produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_mode_reg   <= mode_reg;
            s1_sq_neg_reg <= eff_phase[PHASE_BITS-1];
            s1_first_reg  <= (eff_idx == '0);
            s1_last_reg   <= (eff_idx == total_reg - 32'd1);
            for (int j = 0; j < NT; j++) begin
                s1_addr_reg[j] <= addr_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: table lookup, sign and magnitude
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NT; g++) begin : g_sine
        mttg_sine #(
            .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
        ) u_sine (
            .addr  (s1_addr_reg[g]),
            .value (wave[g])
        );
    end

    always_comb begin
        case (s1_mode_reg) inside
            mttg_pkg::MODE_SINE, mttg_pkg::MODE_CHIRP: val = 18'(wave[0]);
            mttg_pkg::MODE_TONES: val = 18'(wave[0]) + 18'(wave[1]) + 18'(wave[2])
                                        + 18'(wave[3]);
            // full scale times peak over full scale gives peak exactly
            mttg_pkg::MODE_SQUARE: val = s1_sq_neg_reg ? -18'sd32767 : 18'sd32767;
            mttg_pkg::MODE_IMPULSE: val = s1_first_reg ? 18'sd32767 : 18'sd0;
            default: val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (rdy2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_neg_reg  <= val[17];
            s2_mag_reg  <= val[17] ? 17'(-val) : val[16:0];
            s2_div4_reg <= (s1_mode_reg == mttg_pkg::MODE_TONES);
            s2_last_reg <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: amplitude multiply; the four-tone sum also divides by 4
    // ------------------------------------------------------------------
    assign prod = 32'(s2_mag_reg) * 32'(peak_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (rdy3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_x_reg    <= s2_div4_reg ? prod[31:2] : prod[29:0];
            s3_neg_reg  <= s2_neg_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output: divide by 32767 (estimate low by at most one, then correct)
    // ------------------------------------------------------------------
    always_comb begin
        est_sum = 31'(s3_x_reg) + 31'(s3_x_reg[29:15]);
        q0      = est_sum[30:15];
        rem     = 32'(s3_x_reg) + 32'(q0) - (32'(q0) << 15);
        quot    = (rem >= 32'(mttg_pkg::FULL_Q15)) ? q0 + 16'd1 : q0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy_out) begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            m_sample_reg <= s3_neg_reg ? -quot : quot;
            m_last_reg   <= s3_last_reg;
        end
    end

endmodule

/* src/mttg_sine.sv */
// ----------------------------------------------------------------------------
// mttg_sine: full-wave Q15 sine lookup
// Reads a quarter-wave table built at elaboration and unfolds it by
// quadrant into a signed sample.
// ----------------------------------------------------------------------------
module mttg_sine #(
    parameter int TABLE_ADDR_BITS = mttg_pkg::DEF_TABLE_ADDR_BITS
) (
    input  logic [TABLE_ADDR_BITS-1:0]         addr,
    output logic signed [mttg_pkg::SAMPLE_W-1:0] value
);

    localparam int QB      = TABLE_ADDR_BITS - 2;
    localparam int QUARTER = 1 << QB;

    logic [mttg_pkg::PEAK_W-1:0] qtab [QUARTER+1];
    logic [1:0]                  quad;
    logic [QB-1:0]               offs;
    logic [QB:0]                 idx;
    logic [mttg_pkg::SAMPLE_W-1:0] mag;

    for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
        assign qtab[g] = mttg_pkg::quarter_sine(g, QB);
    end

    always_comb begin
        quad = addr[TABLE_ADDR_BITS-1 -: 2];
        offs = addr[QB-1:0];
        // odd quadrants run the quarter wave backwards
        idx  = quad[0] ? ((QB+1)'(QUARTER) - {1'b0, offs}) : {1'b0, offs};
        mag  = {1'b0, qtab[idx]};
        value = quad[1] ? -$signed(mag) : $signed(mag);
    end

endmodule
